// File: hw/rtl/obb_aabb_overlap_test_core_macros.svh
// Assertion macros for the oriented-box overlap test core.
`ifndef OBB_AABB_OVERLAP_TEST_CORE_MACROS_SVH
`define OBB_AABB_OVERLAP_TEST_CORE_MACROS_SVH
`ifndef SYNTH
`define OBB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OBB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OBB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define OBB_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/obbat_pkg.sv
// Shared constants and types for the oriented-box overlap test core.
`timescale 1ns / 1ps
package obbat_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int AXIS_BITS_DEF  = 16;
    localparam int REG_BITS       = 48;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER   = 3'd0,
        CFG_HALF_EXT = 3'd1,
        CFG_ROW0     = 3'd2,
        CFG_ROW1     = 3'd3,
        CFG_ROW2     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic advance;
    } pipe_ctl_t;
endpackage

// File: hw/rtl/obbat_pipe_ctl.sv
// Valid and stall control for the fixed-depth pipeline with an output slot.
`timescale 1ns / 1ps
`include "obb_aabb_overlap_test_core_macros.svh"
module obbat_pipe_ctl #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output obbat_pkg::pipe_ctl_t ctl
);
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             advance;

    assign advance   = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = vld_reg[DEPTH-1];
    assign ctl.advance = advance;

    always_comb begin
        vld_next = vld_reg;
        if (advance) begin
            vld_next = {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    `OBB_ASSERT_NXT(a_hold, aclk, aresetn, out_valid && !out_ready, out_valid)
    `OBB_ASSERT_NXT(a_move, aclk, aresetn, in_valid && in_ready, vld_reg[0])
    `OBB_ASSERT_IMP(a_stall, aclk, aresetn, out_valid && !out_ready, !in_ready)
endmodule

// File: hw/rtl/obbat_datapath.sv
// Separating-axis datapath: projections, products and the 15 axis compares.
`timescale 1ns / 1ps
module obbat_datapath #(
    parameter int COORD_BITS = obbat_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = obbat_pkg::AXIS_BITS_DEF
) (
    input  logic                         aclk,
    input  obbat_pkg::pipe_ctl_t         ctl,
    input  logic [obbat_pkg::REG_BITS-1:0] center,
    input  logic [obbat_pkg::REG_BITS-1:0] half_ext,
    input  logic [obbat_pkg::REG_BITS-1:0] row0,
    input  logic [obbat_pkg::REG_BITS-1:0] row1,
    input  logic [obbat_pkg::REG_BITS-1:0] row2,
    input  logic signed [COORD_BITS-1:0] min_x,
    input  logic signed [COORD_BITS-1:0] min_y,
    input  logic signed [COORD_BITS-1:0] min_z,
    input  logic signed [COORD_BITS-1:0] max_x,
    input  logic signed [COORD_BITS-1:0] max_y,
    input  logic signed [COORD_BITS-1:0] max_z,
    output logic                         overlap
);
    localparam int RB   = obbat_pkg::REG_BITS;
    localparam int FR   = AXIS_BITS - 2;
    localparam int TW   = COORD_BITS + 3;
    localparam int AW   = COORD_BITS + 2;
    localparam int RW   = AXIS_BITS + 1;
    localparam int PW   = TW + RW;
    localparam int TAW  = PW + 2;
    localparam int SW   = AW + RW + 4;
    localparam int CW   = TAW + RW + 2;
    localparam int CRW  = SW + FR + 2;

    logic signed [COORD_BITS-1:0] lo [3];
    logic signed [COORD_BITS-1:0] hi [3];
    logic signed [RW-1:0]         rr [3][3];
    logic signed [RW-1:0]         ar [3][3];
    logic signed [AW-1:0]         ah [3];
    logic [RB-1:0]                rows [3];

    assign lo[0] = min_x; assign lo[1] = min_y; assign lo[2] = min_z;
    assign hi[0] = max_x; assign hi[1] = max_y; assign hi[2] = max_z;
    assign rows[0] = row0; assign rows[1] = row1; assign rows[2] = row2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if ((i + 1) * COORD_BITS <= RB) begin
                ah[i] = AW'({1'b0, half_ext[i*COORD_BITS +: COORD_BITS], 1'b0});
            end else begin
                ah[i] = '0;
            end
            for (int j = 0; j < 3; j++) begin
                if ((j + 1) * AXIS_BITS <= RB) begin
                    rr[i][j] = RW'($signed(rows[i][j*AXIS_BITS +: AXIS_BITS]));
                end else begin
                    rr[i][j] = '0;
                end
                ar[i][j] = (rr[i][j] < 0 ? -rr[i][j] : rr[i][j]) + RW'(1);
            end
        end
    end

    // stage 1: doubled offset and extent
    logic signed [TW-1:0] t_reg [3];
    logic signed [TW-1:0] e_reg [3];
    logic signed [COORD_BITS-1:0] c_s [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if ((k + 1) * COORD_BITS <= RB) begin
                c_s[k] = $signed(center[k*COORD_BITS +: COORD_BITS]);
            end else begin
                c_s[k] = '0;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            for (int k = 0; k < 3; k++) begin
                t_reg[k] <= TW'(lo[k]) + TW'(hi[k]) - (TW'(c_s[k]) <<< 1);
                e_reg[k] <= TW'(hi[k]) - TW'(lo[k]);
            end
        end
    end

    // stage 2: projection products and radius products
    logic signed [PW-1:0] tp_reg [3][3];
    logic signed [TW-1:0] t2_reg [3];
    logic signed [TW-1:0] e2_reg [3];
    logic signed [SW-1:0] ra_reg [3];
    logic signed [SW-1:0] rb_reg [3];
    logic signed [SW-1:0] ea_reg [3][3];
    logic signed [SW-1:0] aa_reg [3][3];
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            for (int i = 0; i < 3; i++) begin
                t2_reg[i] <= t_reg[i];
                e2_reg[i] <= e_reg[i];
                for (int j = 0; j < 3; j++) begin
                    tp_reg[i][j] <= PW'(t_reg[j]) * PW'(rr[i][j]);
                    ea_reg[i][j] <= SW'(e_reg[j]) * SW'(ar[i][j]);
                    aa_reg[i][j] <= SW'(ah[i]) * SW'(ar[i][j]);
                end
                ra_reg[i] <= SW'(ah[i]) <<< FR;
                rb_reg[i] <= SW'(e_reg[i]) <<< FR;
            end
        end
    end

    // stage 3: sums and the six face-axis tests
    logic signed [TAW-1:0] ta_reg [3];
    logic signed [TW-1:0]  e3_reg [3];
    logic                  face_reg;
    logic                  face_c;
    logic signed [TAW-1:0] ta_c [3];
    logic signed [CRW-1:0] l_c, r_c;
    always_comb begin
        face_c = 1'b1;
        for (int i = 0; i < 3; i++) begin
            ta_c[i] = TAW'(tp_reg[i][0]) + TAW'(tp_reg[i][1]) + TAW'(tp_reg[i][2]);
            l_c = CRW'(ta_c[i] < 0 ? -ta_c[i] : ta_c[i]);
            r_c = CRW'(ra_reg[i]) + CRW'(ea_reg[i][0]) + CRW'(ea_reg[i][1])
                + CRW'(ea_reg[i][2]);
            if (l_c > r_c) face_c = 1'b0;
        end
        for (int j = 0; j < 3; j++) begin
            l_c = CRW'(t2_reg[j] < 0 ? -t2_reg[j] : t2_reg[j]) <<< FR;
            r_c = CRW'(aa_reg[0][j]) + CRW'(aa_reg[1][j]) + CRW'(aa_reg[2][j])
                + CRW'(rb_reg[j]);
            if (l_c > r_c) face_c = 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            ta_reg   <= ta_c;
            e3_reg   <= e2_reg;
            face_reg <= face_c;
        end
    end

    // stage 4: cross-axis products
    logic signed [CW-1:0]  cl_reg [3][3];
    logic signed [CRW-1:0] cr_reg [3][3];
    logic                  face4_reg;
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            face4_reg <= face_reg;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cl_reg[i][j] <= CW'(ta_reg[(i+2)%3]) * CW'(rr[(i+1)%3][j])
                                  - CW'(ta_reg[(i+1)%3]) * CW'(rr[(i+2)%3][j]);
                    cr_reg[i][j] <= (CRW'(SW'(ah[(i+1)%3]) * SW'(ar[(i+2)%3][j]))
                                   + CRW'(SW'(ah[(i+2)%3]) * SW'(ar[(i+1)%3][j]))
                                   + CRW'(SW'(e3_reg[(j+1)%3]) * SW'(ar[i][(j+2)%3]))
                                   + CRW'(SW'(e3_reg[(j+2)%3]) * SW'(ar[i][(j+1)%3])))
                                   <<< FR;
                end
            end
        end
    end

    // stage 5: cross-axis compares
    logic ov_reg;
    logic ov_c;
    logic signed [CW-1:0] al_c;
    always_comb begin
        ov_c = face4_reg;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                al_c = cl_reg[i][j] < 0 ? -cl_reg[i][j] : cl_reg[i][j];
                if ($signed({1'b0, al_c}) > $signed({{(CW-CRW+1){cr_reg[i][j][CRW-1]}},
                                                     cr_reg[i][j]})) ov_c = 1'b0;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            ov_reg <= ov_c;
        end
    end
    assign overlap = ov_reg;
endmodule

// File: hw/rtl/obb_aabb_overlap_test_core.sv
// Top level of the oriented-box versus axis-aligned-box overlap test core.
// Usage:
//   Input channel s_*: one axis-aligned box per request, min and max corners.
//   Result channel m_*: one result per box, m_overlap = 1 when the boxes
//   overlap under the 15-axis separating test (ties count as overlap).
//   Oriented box: written through cfg_we/cfg_idx/cfg_data while idle;
//   index 0 center, 1 half-extents, 2..4 axis rows. Other indexes drop.
// Pipeline: a request passes the five datapath register stages, the last
//   of which is the output register, all advancing together.
// Throughput: one box per cycle while the result channel does not stall.
// Reset: clears all pipeline valid bits and loads a zero center, zero
//   half-extents and identity rows.
// Stall: when m_ready is low with a result waiting, the whole pipeline
//   holds and s_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module obb_aabb_overlap_test_core #(
    parameter int COORD_BITS = obbat_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = obbat_pkg::AXIS_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [obbat_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [obbat_pkg::REG_BITS-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_box_min_x,
    input  logic signed [COORD_BITS-1:0] s_box_min_y,
    input  logic signed [COORD_BITS-1:0] s_box_min_z,
    input  logic signed [COORD_BITS-1:0] s_box_max_x,
    input  logic signed [COORD_BITS-1:0] s_box_max_y,
    input  logic signed [COORD_BITS-1:0] s_box_max_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_overlap
);
    localparam int RB = obbat_pkg::REG_BITS;
    localparam int FR = AXIS_BITS - 2;

    logic [RB-1:0] center_reg, half_reg, row0_reg, row1_reg, row2_reg;
    obbat_pkg::pipe_ctl_t ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            half_reg   <= '0;
            row0_reg   <= (FR < RB) ? (RB'(1) << FR) : '0;
            row1_reg   <= (AXIS_BITS + FR < RB) ? (RB'(1) << (AXIS_BITS + FR)) : '0;
            row2_reg   <= (2*AXIS_BITS + FR < RB) ? (RB'(1) << (2*AXIS_BITS + FR)) : '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                obbat_pkg::CFG_CENTER:   center_reg <= cfg_data;
                obbat_pkg::CFG_HALF_EXT: half_reg   <= cfg_data;
                obbat_pkg::CFG_ROW0:     row0_reg   <= cfg_data;
                obbat_pkg::CFG_ROW1:     row1_reg   <= cfg_data;
                obbat_pkg::CFG_ROW2:     row2_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    obbat_pipe_ctl #(.DEPTH(5)) u_ctl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .ctl(ctl)
    );

    obbat_datapath #(.COORD_BITS(COORD_BITS), .AXIS_BITS(AXIS_BITS)) u_dp (
        .aclk(aclk), .ctl(ctl),
        .center(center_reg), .half_ext(half_reg),
        .row0(row0_reg), .row1(row1_reg), .row2(row2_reg),
        .min_x(s_box_min_x), .min_y(s_box_min_y), .min_z(s_box_min_z),
        .max_x(s_box_max_x), .max_y(s_box_max_y), .max_z(s_box_max_z),
        .overlap(m_overlap)
    );
endmodule
